[hw/rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes and result widths for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int OP_W  = 3;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_SIMP = 3'd4;

endpackage

[hw/rtl/rau_gcd.sv]
// ----------------------------------------------------------------------------
// rau_gcd
// Binary GCD of two nonzero magnitudes, one compare/subtract/shift per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] x,
  input  logic [OPERAND_WIDTH-1:0] y,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] g
);

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(W);

  logic [W-1:0]  x_r, y_r, g_r;
  logic [KW-1:0] k_r;
  logic          run_r, done_r;

  logic          both_even, x_ge, finished;
  logic [W-1:0]  diff;

  assign both_even = !x_r[0] && !y_r[0];
  assign x_ge      = x_r >= y_r;
  assign diff      = x_ge ? (x_r - y_r) : (y_r - x_r);
  assign finished  = (x_r == '0) || (y_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && finished) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
      k_r <= '0;
    end else if (run_r) begin
      if (finished) begin
        // common power of two goes back on at the end
        g_r <= (x_r | y_r) << k_r;
      end else if (both_even) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_ge) begin
        x_r <= diff >> 1;
      end else begin
        y_r <= diff >> 1;
      end
    end
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

[hw/rtl/rau_div.sv]
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] quotient
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, q_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;

  logic [W:0]    rem_sh, trial;
  logic          ge;

  assign rem_sh = {rem_r, q_r[W-1]};
  assign trial  = rem_sh - {1'b0, d_r};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CW'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      d_r   <= divisor;
      cnt_r <= CW'(W);
    end else if (run_r) begin
      rem_r <= ge ? trial[W-1:0] : rem_sh[W-1:0];
      q_r   <= {q_r[W-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[hw/rtl/rational_arithmetic_unit_top.sv]
// Add/sub/mul/div take their products in turn from the shared multiplier;
// simplify runs the binary GCD loop, then divides numerator and denominator
// by it. Error cases are answered from idle. One request at a time: busy is
// high from acceptance until the result strobe; error and zero-numerator
// simplify requests never raise it. The result receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle and clears the strobe.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Fraction add/sub/mul/div through one shared multiplier, and GCD reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [rau_pkg::OP_W-1:0]           in_operation,
  input  logic signed [OPERAND_WIDTH-1:0]    in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]    in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]    in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]    in_b_den,
  output logic                               out_valid,
  output logic signed [rau_pkg::NUM_W-1:0]   out_res_num,
  output logic signed [rau_pkg::DEN_W-1:0]   out_res_den,
  output logic                               out_error
);

  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_GCD  = 5'b00100,
    S_DIVN = 5'b01000,
    S_DIVD = 5'b10000
  } state_t;

  state_t                  state_r;
  logic [OP_W-1:0]         op_r;
  logic signed [W-1:0]     an_r, ad_r, bn_r, bd_r;
  logic [W-1:0]            mag_an_r, mag_ad_r, g_r;
  logic signed [W-1:0]     qn_r;
  logic [1:0]              step_r;
  logic signed [2*W-1:0]   prod_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [NUM_W-1:0] out_num_r;
  logic signed [DEN_W-1:0] out_den_r;
  logic                    out_err_r, out_valid_r;

  logic                    accept, bad_req, zero_simp;
  logic                    op_addsub, op_is_sub;
  logic [1:0]              last_step;
  logic signed [W-1:0]     mul_a, mul_b;
  logic signed [2*W-1:0]   prod;
  logic [W-1:0]            in_mag_an, in_mag_ad;
  logic                    gcd_start, gcd_done;
  logic [W-1:0]            gcd_g;
  logic                    div_start, div_done;
  logic [W-1:0]            div_dividend, div_divisor, div_q;
  logic signed [W-1:0]     q_signed;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);

  assign in_mag_an = in_a_num[W-1] ? W'(-in_a_num) : W'(in_a_num);
  assign in_mag_ad = in_a_den[W-1] ? W'(-in_a_den) : W'(in_a_den);

  always_comb begin
    bad_req = 1'b0;
    unique case (in_operation) inside
      OP_ADD, OP_SUB, OP_MUL: bad_req = (in_a_den == '0) || (in_b_den == '0);
      OP_DIV:  bad_req = (in_a_den == '0) || (in_b_den == '0) || (in_b_num == '0);
      OP_SIMP: bad_req = (in_a_den == '0);
      default: bad_req = 1'b1;
    endcase
  end

  // a zero numerator reduces straight to 0/1
  assign zero_simp = (in_operation == OP_SIMP) && (in_a_num == '0);

  assign op_addsub = (op_r == OP_ADD) || (op_r == OP_SUB);
  assign op_is_sub = (op_r == OP_SUB);
  assign last_step = op_addsub ? 2'd3 : 2'd2;

  // operand pairs: numerator terms first, denominator product last
  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        if (op_addsub) begin
          mul_a = bn_r;
          mul_b = ad_r;
        end else begin
          mul_a = ad_r;
          mul_b = (op_r == OP_MUL) ? bd_r : bn_r;
        end
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign gcd_start    = accept && !bad_req && !zero_simp && (in_operation == OP_SIMP);
  assign div_start    = ((state_r == S_GCD) && gcd_done) || ((state_r == S_DIVN) && div_done);
  assign div_dividend = (state_r == S_GCD) ? mag_an_r : mag_ad_r;
  assign div_divisor  = (state_r == S_GCD) ? gcd_g : g_r;

  assign q_signed = ((state_r == S_DIVN) ? an_r[W-1] : ad_r[W-1]) ?
                    W'(-div_q) : W'(div_q);

  rau_gcd #(.OPERAND_WIDTH(W)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .x     (in_mag_an),
    .y     (in_mag_ad),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div #(.OPERAND_WIDTH(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (bad_req || zero_simp) begin
              out_valid_r <= 1'b1;
            end else if (in_operation == OP_SIMP) begin
              state_r <= S_GCD;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (step_r == last_step) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_GCD: begin
          if (gcd_done) state_r <= S_DIVN;
        end
        S_DIVN: begin
          if (div_done) state_r <= S_DIVD;
        end
        S_DIVD: begin
          if (div_done) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_operation;
      an_r      <= in_a_num;
      ad_r      <= in_a_den;
      bn_r      <= in_b_num;
      bd_r      <= in_b_den;
      mag_an_r  <= in_mag_an;
      mag_ad_r  <= in_mag_ad;
      step_r    <= '0;
      out_num_r <= '0;
      out_den_r <= DEN_W'(1);
      out_err_r <= bad_req;
    end else begin
      unique case (state_r)
        S_MUL: begin
          prod_r <= prod;
          step_r <= step_r + 2'd1;
          if (step_r == last_step) begin
            out_num_r <= num_r;
            out_den_r <= DEN_W'(prod_r);
            out_err_r <= 1'b0;
          end else if (step_r == 2'd1) begin
            num_r <= NUM_W'(prod_r);
          end else if (step_r == 2'd2) begin
            num_r <= op_is_sub ? (num_r - NUM_W'(prod_r)) : (num_r + NUM_W'(prod_r));
          end
        end
        S_GCD: begin
          if (gcd_done) g_r <= gcd_g;
        end
        S_DIVN: begin
          if (div_done) qn_r <= q_signed;
        end
        S_DIVD: begin
          if (div_done) begin
            out_num_r <= NUM_W'(qn_r);
            out_den_r <= DEN_W'(q_signed);
            out_err_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_error   = out_err_r;

  a_bad_op_err: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation > OP_SIMP) |=> out_valid && out_error)
    else $error("unknown operation did not flag an error");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> (out_res_num == '0) && (out_res_den == DEN_W'(1)))
    else $error("error result is not 0/1");

  a_gcd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_done |-> (state_r == S_GCD))
    else $error("GCD finished outside its step");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVN) || (state_r == S_DIVD))
    else $error("division finished outside its steps");

  a_simp_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(state_r == S_DIVD) |-> (out_res_den != '0) && !out_error)
    else $error("reduced denominator is zero");

endmodule
